FILE: rtl/core/tds_pkg.sv
`default_nettype none

package tds_pkg;

  localparam int CNT_W      = 8;
  localparam int DELTA_W    = CNT_W + 1;
  localparam int FRAC_W     = 8;
  localparam int FILT_W     = 18;
  localparam int DIFF_W     = FILT_W + 2;
  localparam int MAG_W      = FILT_W - FRAC_W;
  localparam int SMAG_W     = MAG_W + 1;
  localparam int GAIN_W     = 8;
  localparam int PROD_W     = SMAG_W + GAIN_W + 1;
  localparam int MOVE_W     = 17;
  localparam int SHIFT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef logic [CNT_W-1:0]             count_t;
  typedef logic signed [DELTA_W-1:0]    delta_t;
  typedef logic signed [FILT_W-1:0]     filt_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic signed [MOVE_W-1:0]     move_t;
  typedef logic [SHIFT_W-1:0]           shift_t;
  typedef logic [GAIN_W-1:0]            gain_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]        cfg_data_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t REG_EMA_SHIFT    = 3'd0;
  localparam cfg_idx_t REG_SWAP_AXES    = 3'd1;
  localparam cfg_idx_t REG_INVERT_H     = 3'd2;
  localparam cfg_idx_t REG_INVERT_V     = 3'd3;
  localparam cfg_idx_t REG_GAIN_X       = 3'd4;
  localparam cfg_idx_t REG_GAIN_Y       = 3'd5;
  localparam cfg_idx_t REG_IDLE_LIMIT   = 3'd6;

  localparam shift_t EMA_SHIFT_RST    = 3'd2;
  localparam gain_t  GAIN_RST         = 8'd1;
  localparam count_t IDLE_LIMIT_RST   = 8'd50;

  // Half of one Q8 unit, added before truncation to round half away from zero.
  localparam logic [FILT_W:0] ROUND_HALF = (FILT_W+1)'(128);

  // One exponential moving average step in Q8: f + ((d << 8) - f) >>> k,
  // wrapped to the filter width.
  function automatic filt_t filter_step(filt_t f, delta_t d, shift_t k);
    logic signed [DIFF_W-1:0] f_ext;
    logic signed [DIFF_W-1:0] target;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] shifted;
    logic signed [DIFF_W-1:0] sum;
    f_ext   = {{(DIFF_W-FILT_W){f[FILT_W-1]}}, f};
    target  = {{(DIFF_W-DELTA_W-FRAC_W){d[DELTA_W-1]}}, d, {FRAC_W{1'b0}}};
    diff    = target - f_ext;
    shifted = diff >>> k;
    sum     = f_ext + shifted;
    return sum[FILT_W-1:0];
  endfunction

  // Magnitude of a Q8 value rounded to an integer, half away from zero.
  function automatic mag_t round_mag(filt_t v);
    logic [FILT_W-1:0] a;
    logic [FILT_W:0]   r;
    a = v[FILT_W-1] ? (~v + 1'b1) : v;
    r = {1'b0, a} + ROUND_HALF;
    return r[FILT_W-1:FRAC_W];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/trackball_delta_smoother.sv
`default_nettype none

// Trackball delta smoother. Each input item is one sensor sample (up, down,
// left and right counts plus a status byte); each produces exactly one result
// item. The raw deltas right - left and down - up are low-passed per axis by a
// Q8 exponential moving average with weight 2^-ema_shift, rounded half away
// from zero, then swapped, inverted and multiplied by the per-axis gain, in
// that order. The result also carries the switch state, a flag for a switch
// change since the previous sample, and an idle flag raised once idle_limit
// motionless samples have been seen in a row. The block takes one item per
// clock unless out_ready holds it back. The first stage updates the filter
// state, idle counter and switch history, the second does rounding, orientation
// and the gain multiply into the result register. The stage between them lets
// a new item enter while a finished result is still waiting on out_ready.
// Configuration registers must be written only while no item is in flight;
// they take effect for the next accepted item.
module trackball_delta_smoother #(
  parameter logic [7:0] SWITCH_MASK = 8'd128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                cfg_we,
  input  wire tds_pkg::cfg_idx_t   cfg_index,
  input  wire tds_pkg::cfg_data_t  cfg_wdata,

  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tds_pkg::count_t     in_up_count,
  input  wire tds_pkg::count_t     in_down_count,
  input  wire tds_pkg::count_t     in_left_count,
  input  wire tds_pkg::count_t     in_right_count,
  input  wire tds_pkg::count_t     in_switch_byte,

  output logic                     out_valid,
  input  wire logic                out_ready,
  output tds_pkg::move_t           out_move_x,
  output tds_pkg::move_t           out_move_y,
  output logic                     out_x_valid,
  output logic                     out_y_valid,
  output logic                     out_button_pressed,
  output logic                     out_button_changed,
  output logic                     out_idle
);

  import tds_pkg::*;

  // Configuration registers.
  shift_t ema_shift_r;
  logic   swap_axes_r;
  logic   invert_h_r;
  logic   invert_v_r;
  gain_t  gain_x_r;
  gain_t  gain_y_r;
  count_t idle_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ema_shift_r    <= EMA_SHIFT_RST;
      swap_axes_r    <= 1'b0;
      invert_h_r     <= 1'b0;
      invert_v_r     <= 1'b0;
      gain_x_r       <= GAIN_RST;
      gain_y_r       <= GAIN_RST;
      idle_limit_r   <= IDLE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EMA_SHIFT:    ema_shift_r    <= cfg_wdata[SHIFT_W-1:0];
        REG_SWAP_AXES:    swap_axes_r    <= cfg_wdata[0];
        REG_INVERT_H:     invert_h_r     <= cfg_wdata[0];
        REG_INVERT_V:     invert_v_r     <= cfg_wdata[0];
        REG_GAIN_X:       gain_x_r       <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_Y:       gain_y_r       <= cfg_wdata[GAIN_W-1:0];
        REG_IDLE_LIMIT:   idle_limit_r   <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake. The first stage holds one item between the state update and
  // the result register; it moves on whenever the result register is free or
  // being emptied in the same cycle.
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_fire;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // First stage: filter update, idle counting and switch edge detection.
  filt_t  filt_x_r, filt_x_nxt;
  filt_t  filt_y_r, filt_y_nxt;
  count_t idle_cnt_r, idle_cnt_nxt;
  logic   btn_prev_r;
  delta_t dx;
  delta_t dy;
  logic   motion;
  logic   pressed;

  always_comb begin
    dx         = $signed({1'b0, in_right_count}) - $signed({1'b0, in_left_count});
    dy         = $signed({1'b0, in_down_count}) - $signed({1'b0, in_up_count});
    filt_x_nxt = filter_step(filt_x_r, dx, ema_shift_r);
    filt_y_nxt = filter_step(filt_y_r, dy, ema_shift_r);
    motion     = (dx != '0) || (dy != '0);
    // A counter left above a lowered limit simply holds.
    if (motion) begin
      idle_cnt_nxt = '0;
    end else if (idle_cnt_r < idle_limit_r) begin
      idle_cnt_nxt = idle_cnt_r + 1'b1;
    end else begin
      idle_cnt_nxt = idle_cnt_r;
    end
    pressed = (in_switch_byte & SWITCH_MASK) != '0;
  end

  logic s1_pressed_r;
  logic s1_changed_r;
  logic s1_idle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      filt_x_r   <= '0;
      filt_y_r   <= '0;
      idle_cnt_r <= '0;
      btn_prev_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        filt_x_r   <= filt_x_nxt;
        filt_y_r   <= filt_y_nxt;
        idle_cnt_r <= idle_cnt_nxt;
        btn_prev_r <= pressed;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pressed_r <= pressed;
      s1_changed_r <= pressed != btn_prev_r;
      s1_idle_r    <= idle_cnt_nxt >= idle_limit_r;
    end
  end

  // Second stage. The filter registers always belong to the item held in the
  // first stage, because a new item only enters as that one moves on.
  filt_t                     sel_x;
  filt_t                     sel_y;
  logic                      neg_x;
  logic                      neg_y;
  mag_t                      mag_x;
  mag_t                      mag_y;
  logic signed [SMAG_W-1:0]  sx;
  logic signed [SMAG_W-1:0]  sy;
  logic signed [PROD_W-1:0]  prod_x;
  logic signed [PROD_W-1:0]  prod_y;

  always_comb begin
    sel_x  = swap_axes_r ? filt_y_r : filt_x_r;
    sel_y  = swap_axes_r ? filt_x_r : filt_y_r;
    // Sign of the rounded value and the inversion fold into one negation.
    neg_x  = sel_x[FILT_W-1] ^ invert_h_r;
    neg_y  = sel_y[FILT_W-1] ^ invert_v_r;
    mag_x  = round_mag(sel_x);
    mag_y  = round_mag(sel_y);
    sx     = neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    sy     = neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
    prod_x = sx * $signed({1'b0, gain_x_r});
    prod_y = sy * $signed({1'b0, gain_y_r});
  end

  move_t out_move_x_r;
  move_t out_move_y_r;
  logic  out_x_valid_r;
  logic  out_y_valid_r;
  logic  out_pressed_r;
  logic  out_changed_r;
  logic  out_idle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_move_x_r  <= prod_x[MOVE_W-1:0];
      out_move_y_r  <= prod_y[MOVE_W-1:0];
      out_x_valid_r <= prod_x != '0;
      out_y_valid_r <= prod_y != '0;
      out_pressed_r <= s1_pressed_r;
      out_changed_r <= s1_changed_r;
      out_idle_r    <= s1_idle_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_move_x         = out_move_x_r;
  assign out_move_y         = out_move_y_r;
  assign out_x_valid        = out_x_valid_r;
  assign out_y_valid        = out_y_valid_r;
  assign out_button_pressed = out_pressed_r;
  assign out_button_changed = out_changed_r;
  assign out_idle           = out_idle_r;

  // The held first-stage item is never overwritten by a new one.
  a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_fire)
    else $error("first stage item overwritten");

  // Sideways motion always clears the idle counter.
  a_motion_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_right_count != in_left_count)) |=> (idle_cnt_r == '0))
    else $error("idle counter not cleared on motion");

  // Switch history follows the switch state carried with the item.
  a_btn_history: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (btn_prev_r == s1_pressed_r))
    else $error("switch history out of step");

  // Valid flags agree with the registered movement values.
  a_valid_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_x_valid_r == (out_move_x_r != '0)) &&
                     (out_y_valid_r == (out_move_y_r != '0))))
    else $error("movement valid flag mismatch");

endmodule

`default_nettype wire

FILE: bench/trackball_delta_smoother_tb.sv
`default_nettype none

// Self-checking bench for the trackball delta smoother.
//
// A predictor inside this module keeps its own copy of the Q8 filter state, the
// idle counter, the switch history and the tuning registers. Every item the
// block accepts is run through the predictor, and the outcome is queued. One
// process plays the result receiver: it stalls at random, takes each result
// item and compares it field by field with the oldest queued expectation.
//
// The stimulus runs as a series of named tests. Directed items cover the count
// extremes, rounding of a half step, orientation and gain extremes and the idle
// limit corner cases. A back-pressure test and several random phases follow,
// each phase with its own tuning.
module trackball_delta_smoother_tb;
  import tds_pkg::*;

  localparam logic [7:0] SWITCH_BIT_MASK = 8'd128;
  // Longest random wait of either side, in cycles.
  localparam int MAX_WAIT = 14;
  // Cycles with no handshake on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 3000;
  // The block holds at most two items in flight, so a few cycles cover it.
  localparam int PIPE_DRAIN = 4;

  typedef struct {
    count_t up, down, left, right, sw;
  } sample_t;

  typedef struct {
    move_t move_x, move_y;
    logic  x_valid, y_valid, pressed, changed, idle;
  } motion_t;

  typedef struct {
    shift_t shift;
    logic   swap, inv_h, inv_v;
    gain_t  gain_x, gain_y;
    count_t idle_lim;
  } tuning_t;

  // Clock, reset and every input of the block, all known from time zero.
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_index = REG_EMA_SHIFT;
  cfg_data_t cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  count_t    in_up_count = '0;
  count_t    in_down_count = '0;
  count_t    in_left_count = '0;
  count_t    in_right_count = '0;
  count_t    in_switch_byte = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  move_t     out_move_x, out_move_y;
  logic      out_x_valid, out_y_valid;
  logic      out_button_pressed, out_button_changed, out_idle;

  // Predictor state. It mirrors the block's reset values.
  filt_t   ema_x = '0;
  filt_t   ema_y = '0;
  count_t  still_count = '0;
  logic    last_pressed = 1'b0;
  tuning_t cur;

  // Expected results, oldest first.
  motion_t pending_moves[$];

  // Traffic shaping. The eager flags switch off random waits on one side; a
  // nonzero hold asks the receiver for one long stall.
  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  int rx_hold = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  trackball_delta_smoother #(
    .SWITCH_MASK(SWITCH_BIT_MASK)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_up_count        (in_up_count),
    .in_down_count      (in_down_count),
    .in_left_count      (in_left_count),
    .in_right_count     (in_right_count),
    .in_switch_byte     (in_switch_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_move_x         (out_move_x),
    .out_move_y         (out_move_y),
    .out_x_valid        (out_x_valid),
    .out_y_valid        (out_y_valid),
    .out_button_pressed (out_button_pressed),
    .out_button_changed (out_button_changed),
    .out_idle           (out_idle)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One moving average step. An arithmetic shift of a signed int floors, which
  // is exactly the rounding the filter uses; the sum wraps to the filter width.
  function automatic filt_t ema_next(filt_t f, int d);
    int fi;
    int moved;
    fi = f;
    moved = fi + ((d * 256 - fi) >>> cur.shift);
    return moved[FILT_W-1:0];
  endfunction

  // Q8 to integer, half away from zero.
  function automatic int q8_round(filt_t v);
    int vi;
    vi = v;
    if (vi >= 0) begin
      return (vi + 128) >>> FRAC_W;
    end
    return -((128 - vi) >>> FRAC_W);
  endfunction

  // Advances the predictor by one sample and returns the result it must cause.
  function automatic motion_t smooth_sample(sample_t s);
    int      dx, dy, ox, oy, tmp;
    logic    pressed;
    motion_t m;
    dx = int'(s.right) - int'(s.left);
    dy = int'(s.down) - int'(s.up);
    ema_x = ema_next(ema_x, dx);
    ema_y = ema_next(ema_y, dy);
    ox = q8_round(ema_x);
    oy = q8_round(ema_y);
    // Swap first, then invert, then the gain, in that order.
    if (cur.swap) begin
      tmp = ox;
      ox = oy;
      oy = tmp;
    end
    if (cur.inv_h) begin
      ox = -ox;
    end
    if (cur.inv_v) begin
      oy = -oy;
    end
    ox = ox * int'(cur.gain_x);
    oy = oy * int'(cur.gain_y);
    // Raw motion clears the idle count; otherwise it creeps up to the limit
    // and is held there, or above it if the limit has since been lowered.
    if (dx != 0 || dy != 0) begin
      still_count = '0;
    end else if (still_count < cur.idle_lim) begin
      still_count = still_count + 8'd1;
    end
    pressed = (s.sw & SWITCH_BIT_MASK) != 8'd0;
    m.move_x = ox[MOVE_W-1:0];
    m.move_y = oy[MOVE_W-1:0];
    m.x_valid = (ox != 0);
    m.y_valid = (oy != 0);
    m.pressed = pressed;
    m.changed = (pressed != last_pressed);
    m.idle = (still_count >= cur.idle_lim);
    last_pressed = pressed;
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample and tuning sources
  // ---------------------------------------------------------------------------

  function automatic sample_t reading(count_t up, count_t down, count_t left,
                                      count_t right, count_t sw);
    sample_t s;
    s.up = up;
    s.down = down;
    s.left = left;
    s.right = right;
    s.sw = sw;
    return s;
  endfunction

  // A sample with no raw motion: opposite counts are equal, often both zero.
  function automatic sample_t still_sample();
    sample_t s;
    count_t  h, v;
    h = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    v = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    s = reading(v, v, h, h, 8'($urandom_range(0, 255)));
    return s;
  endfunction

  // Small movements, where rounding and the filter tail matter, as often as
  // full-range counts, with motionless samples mixed in.
  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0, 1: begin
        s = still_sample();
      end
      2, 3, 4, 5: begin
        s = reading(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                    8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                    8'($urandom_range(0, 255)));
      end
      default: begin
        s = reading(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      end
    endcase
    return s;
  endfunction

  function automatic tuning_t default_tuning();
    tuning_t t;
    t.shift = EMA_SHIFT_RST;
    t.swap = 1'b0;
    t.inv_h = 1'b0;
    t.inv_v = 1'b0;
    t.gain_x = GAIN_RST;
    t.gain_y = GAIN_RST;
    t.idle_lim = IDLE_LIMIT_RST;
    return t;
  endfunction

  // Gains favor the extremes and unity, where mistakes show most clearly.
  function automatic gain_t pick_gain();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic tuning_t random_tuning();
    tuning_t t;
    t.shift = shift_t'($urandom_range(0, 7));
    t.swap = 1'($urandom_range(0, 1));
    t.inv_h = 1'($urandom_range(0, 1));
    t.inv_v = 1'($urandom_range(0, 1));
    t.gain_x = pick_gain();
    t.gain_y = pick_gain();
    case ($urandom_range(0, 4))
      0:       t.idle_lim = 8'd0;
      1:       t.idle_lim = 8'd1;
      2:       t.idle_lim = 8'd255;
      default: t.idle_lim = 8'($urandom_range(1, 20));
    endcase
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offers one item after a random gap and returns at the edge that takes it.
  // Valid stays high afterwards, so back-to-back items need no extra edge.
  task automatic send_sample(sample_t s);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_up_count <= s.up;
    in_down_count <= s.down;
    in_left_count <= s.left;
    in_right_count <= s.right;
    in_switch_byte <= s.sw;
    do @(posedge clk); while (!in_ready);
    pending_moves.push_back(smooth_sample(s));
  endtask

  // Stops offering items and waits until every expected result has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
  endtask

  // Writes all seven registers, one per cycle, once the block has gone quiet.
  task automatic apply_tuning(tuning_t t);
    wait_for_results();
    repeat (PIPE_DRAIN) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_EMA_SHIFT;
    cfg_wdata <= cfg_data_t'(t.shift);
    @(posedge clk);
    cfg_index <= REG_SWAP_AXES;
    cfg_wdata <= cfg_data_t'(t.swap);
    @(posedge clk);
    cfg_index <= REG_INVERT_H;
    cfg_wdata <= cfg_data_t'(t.inv_h);
    @(posedge clk);
    cfg_index <= REG_INVERT_V;
    cfg_wdata <= cfg_data_t'(t.inv_v);
    @(posedge clk);
    cfg_index <= REG_GAIN_X;
    cfg_wdata <= t.gain_x;
    @(posedge clk);
    cfg_index <= REG_GAIN_Y;
    cfg_wdata <= t.gain_y;
    @(posedge clk);
    cfg_index <= REG_IDLE_LIMIT;
    cfg_wdata <= t.idle_lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur = t;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result receiver and checker. Each result item is preceded by a drawn stall,
  // or by the long hold that a test asked for, so that the block fills up.
  initial begin : result_checker
    int      stall;
    motion_t want;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_eager ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_moves.size() == 0) begin
        $error("result item arrived with no sample pending");
        fail_count++;
      end else begin
        want = pending_moves.pop_front();
        check_field("move_x", want.move_x, out_move_x);
        check_field("move_y", want.move_y, out_move_y);
        check_field("x_valid", want.x_valid, out_x_valid);
        check_field("y_valid", want.y_valid, out_y_valid);
        check_field("button_pressed", want.pressed, out_button_pressed);
        check_field("button_changed", want.changed, out_button_changed);
        check_field("idle", want.idle, out_idle);
      end
    end
  end

  // Watchdog: a run that moves no item on either channel for too long is hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("trackball_delta_smoother_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset tuning: count extremes, a half step that must round up, the switch
  // bit alone and among other status bits, and a filter settling negative.
  task automatic test_reset_defaults();
    send_sample(reading(8'd0, 8'd0, 8'd0, 8'd0, 8'h00));
    send_sample(reading(8'd0, 8'd0, 8'd0, 8'd2, 8'h80));
    send_sample(reading(8'd0, 8'd0, 8'd2, 8'd0, 8'h80));
    send_sample(reading(8'd0, 8'd255, 8'd0, 8'd255, 8'h7F));
    send_sample(reading(8'd255, 8'd0, 8'd255, 8'd0, 8'hFF));
    send_sample(reading(8'd255, 8'd255, 8'd255, 8'd255, 8'hFF));
    repeat (3) send_sample(reading(8'd0, 8'd0, 8'd255, 8'd0, 8'h00));
    send_sample(reading(8'd0, 8'd0, 8'd0, 8'd0, 8'h01));
  endtask

  // Swap, both inversions and both gain extremes. With no smoothing the full
  // count range reaches the largest output magnitude in one item; a zero gain
  // must silence its axis and clear its valid bit.
  task automatic test_orientation();
    tuning_t t;
    t = default_tuning();
    t.shift = 3'd0;
    t.swap = 1'b1;
    t.inv_h = 1'b1;
    t.gain_x = 8'd255;
    t.gain_y = 8'd0;
    apply_tuning(t);
    send_sample(reading(8'd255, 8'd0, 8'd0, 8'd255, 8'h80));
    send_sample(reading(8'd0, 8'd255, 8'd255, 8'd0, 8'h00));
    send_sample(reading(8'd0, 8'd0, 8'd0, 8'd0, 8'h80));
    // Heaviest smoothing with the vertical axis inverted.
    t.shift = 3'd7;
    t.swap = 1'b0;
    t.inv_h = 1'b0;
    t.inv_v = 1'b1;
    t.gain_y = 8'd255;
    t.idle_lim = 8'd255;
    apply_tuning(t);
    repeat (2) send_sample(reading(8'd0, 8'd255, 8'd0, 8'd255, 8'h80));
    send_sample(reading(8'd255, 8'd0, 8'd255, 8'd0, 8'h00));
  endtask

  // Idle flag: reaching a small limit, a limit lowered below the current count
  // (the count is held and idle stays up), a limit of zero, and a raised limit.
  task automatic test_idle_limits();
    tuning_t t;
    t = default_tuning();
    t.shift = 3'd1;
    t.idle_lim = 8'd3;
    apply_tuning(t);
    repeat (4) send_sample(reading(8'd0, 8'd0, 8'd0, 8'd0, 8'h00));
    send_sample(reading(8'd9, 8'd9, 8'd200, 8'd200, 8'h00));
    t.idle_lim = 8'd1;
    apply_tuning(t);
    repeat (2) send_sample(reading(8'd0, 8'd0, 8'd0, 8'd0, 8'h00));
    t.idle_lim = 8'd0;
    apply_tuning(t);
    send_sample(reading(8'd0, 8'd0, 8'd0, 8'd0, 8'h80));
    send_sample(reading(8'd0, 8'd1, 8'd0, 8'd0, 8'h80));
    t.idle_lim = 8'd255;
    apply_tuning(t);
    send_sample(reading(8'd0, 8'd0, 8'd0, 8'd0, 8'h00));
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items back to back, so the block must fill and drop in_ready. Then the
  // sender pauses until the pipeline has emptied before carrying on.
  task automatic test_backpressure();
    tx_eager = 1'b1;
    rx_eager = 1'b0;
    rx_hold = 80;
    repeat (30) send_sample(random_sample());
    wait_for_results();
    tx_eager = 1'b0;
    repeat (20) send_sample(random_sample());
  endtask

  // Random phases, each under its own tuning. The first three tunings are the
  // reset values and two sets of extremes; the rest are drawn. Runs of
  // motionless samples now and then drive the idle counter to its limit.
  task automatic test_random_traffic();
    tuning_t t;
    int      sent;
    int      run;
    for (int phase = 0; phase < 8; phase++) begin
      t = (phase == 0) ? default_tuning() : random_tuning();
      if (phase == 1) begin
        t.shift = 3'd0;
        t.swap = 1'b1;
        t.inv_h = 1'b1;
        t.inv_v = 1'b1;
        t.gain_x = 8'd255;
        t.gain_y = 8'd255;
        t.idle_lim = 8'd1;
      end else if (phase == 2) begin
        t.shift = 3'd7;
        t.swap = 1'b0;
        t.inv_h = 1'b0;
        t.inv_v = 1'b0;
        t.gain_x = 8'd1;
        t.gain_y = 8'd0;
        t.idle_lim = 8'd255;
      end
      apply_tuning(t);
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 220) begin
        if ($urandom_range(0, 24) == 0) begin
          run = $urandom_range(1, 60);
          repeat (run) send_sample(still_sample());
          sent += run;
        end else begin
          send_sample(random_sample());
          sent++;
        end
      end
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;
  endtask

  initial begin
    cur = default_tuning();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_orientation();
    test_idle_limits();
    test_backpressure();
    test_random_traffic();

    // Let any stray result item surface before the verdict.
    wait_for_results();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("trackball_delta_smoother_tb: PASS");
    end else begin
      $display("trackball_delta_smoother_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
